// ===== rtl/ptdt_pkg.sv =====
package ptdt_pkg;

    localparam int IdW    = 8;
    localparam int TickW  = 32;
    localparam int SlotW  = 4;
    localparam int PendW  = 8;

    localparam logic [PendW-1:0] PendMax = '1;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2,
        OP_RUN  = 2'd3
    } t_op;

    typedef enum logic {
        KIND_ADD      = 1'b0,
        KIND_DISPATCH = 1'b1
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_state;

    typedef struct packed {
        logic [IdW-1:0]   task_id;
        logic [TickW-1:0] delay;
        logic [TickW-1:0] period;
        logic [PendW-1:0] pending;
    } t_entry;

endpackage

// ===== rtl/ptdt_ifs.sv =====
interface ptdt_req_if;
    logic                            valid;
    logic                            ready;
    ptdt_pkg::t_op                   op;
    logic [ptdt_pkg::IdW-1:0]        task_id;
    logic [ptdt_pkg::TickW-1:0]      delay_load;
    logic [ptdt_pkg::TickW-1:0]      period_load;
    logic [ptdt_pkg::SlotW-1:0]      slot;

    modport source (output valid, op, task_id, delay_load, period_load, slot, input ready);
    modport sink   (input valid, op, task_id, delay_load, period_load, slot, output ready);
endinterface

interface ptdt_res_if;
    logic                            valid;
    logic                            ready;
    ptdt_pkg::t_kind                 kind;
    logic [ptdt_pkg::SlotW-1:0]      slot_index;
    logic                            full_res;
    logic [ptdt_pkg::IdW-1:0]        task_id_out;
    logic                            last;

    modport source (output valid, kind, slot_index, full_res, task_id_out, last, input ready);
    modport sink   (input valid, kind, slot_index, full_res, task_id_out, last, output ready);
endinterface

// ===== rtl/periodic_task_dispatch_table_unit.sv =====
// channel   dir   handshake       contents
// i_req     in    valid/ready     op, task_id, delay_load, period_load, slot
// o_res     out   valid/ready     kind, slot_index, full_res, task_id_out, last
//
// add and delete are done in the idle state that accepts them; tick and run walk every
// slot through the two-port table memory (one read and one write a cycle)
// a run dispatch holds the walk for as long as the output register stays full
// a request is taken only in idle with the output register free or draining
// synchronous active-low reset empties the table through the per-slot occupied flags
module periodic_task_dispatch_table_unit #(
    parameter int SLOTS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ptdt_req_if.sink           i_req,
    ptdt_res_if.source         o_res
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    ptdt_pkg::t_entry r_mem [SLOTS];
    ptdt_pkg::t_entry r_rdata;

    ptdt_pkg::t_state r_state, n_state;
    ptdt_pkg::t_op    r_op;
    logic [SLOTS-1:0] r_occ, r_rdy;
    logic [IW-1:0]    r_ridx, r_pidx;
    logic             r_pv, r_rdone;

    logic                          r_ov;
    ptdt_pkg::t_kind               r_kind;
    logic [ptdt_pkg::SlotW-1:0]    r_slot_index;
    logic                          r_full;
    logic [ptdt_pkg::IdW-1:0]      r_task_out;
    logic                          r_last;

    logic             out_free, req_ready, accept, stall, walk_go;
    logic             free_found, later_rdy, proc_rdy;
    logic [IW-1:0]    free_idx, rd_addr, mem_wa;
    logic             mem_we, res_load;
    ptdt_pkg::t_entry mem_wd, add_ent, proc_ent;
    logic [ptdt_pkg::TickW-1:0] dec;

    assign out_free = !r_ov || o_res.ready;
    assign accept   = i_req.valid && req_ready;
    assign proc_rdy = r_pv && r_op == ptdt_pkg::OP_RUN && r_rdy[r_pidx];

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (!r_occ[j]) begin
                free_found = 1'b1;
                free_idx   = IW'(j);
            end
        end
    end

    // any ready slot above the one in hand
    always_comb begin
        later_rdy = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (j > int'(r_pidx) && r_rdy[j]) begin
                later_rdy = 1'b1;
            end
        end
    end

    always_comb begin
        add_ent.task_id = i_req.task_id;
        add_ent.delay   = i_req.delay_load;
        add_ent.period  = i_req.period_load;
        add_ent.pending = '0;
    end

    // read-modify-write of the slot in hand
    always_comb begin
        proc_ent = r_rdata;
        dec      = r_rdata.delay - ptdt_pkg::TickW'(1);
        if (r_op == ptdt_pkg::OP_TICK) begin
            proc_ent.delay = dec;
            if (dec == '0) begin
                if (r_rdata.pending != ptdt_pkg::PendMax) begin
                    proc_ent.pending = r_rdata.pending + ptdt_pkg::PendW'(1);
                end
                if (r_rdata.period != '0) begin
                    proc_ent.delay = r_rdata.period;
                end
            end
        end else if (r_rdy[r_pidx]) begin
            proc_ent.pending = r_rdata.pending - ptdt_pkg::PendW'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptdt_pkg::ST_IDLE: begin
                if (accept && (i_req.op == ptdt_pkg::OP_TICK || i_req.op == ptdt_pkg::OP_RUN)) begin
                    n_state = ptdt_pkg::ST_WALK;
                end
            end
            ptdt_pkg::ST_WALK: begin
                if (walk_go && r_rdone) begin
                    n_state = ptdt_pkg::ST_IDLE;
                end
            end
            default: n_state = ptdt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        req_ready = 1'b0;
        stall     = 1'b0;
        walk_go   = 1'b0;
        mem_we    = 1'b0;
        mem_wa    = r_pidx;
        mem_wd    = proc_ent;
        res_load  = 1'b0;
        unique case (r_state)
            ptdt_pkg::ST_IDLE: begin
                req_ready = out_free;
                if (accept && i_req.op == ptdt_pkg::OP_ADD) begin
                    mem_we   = free_found;
                    mem_wa   = free_idx;
                    mem_wd   = add_ent;
                    res_load = 1'b1;
                end
            end
            ptdt_pkg::ST_WALK: begin
                stall    = proc_rdy && !out_free;
                walk_go  = !stall;
                mem_we   = walk_go && r_pv && r_occ[r_pidx];
                res_load = walk_go && proc_rdy;
            end
            default: ;
        endcase
    end

    assign rd_addr = stall ? r_pidx : r_ridx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptdt_pkg::ST_IDLE;
            r_occ   <= '0;
            r_rdy   <= '0;
            r_pv    <= 1'b0;
            r_rdone <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (res_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == ptdt_pkg::ST_IDLE) begin
                r_pv    <= 1'b0;
                r_rdone <= 1'b0;
                if (accept) begin
                    case (i_req.op)
                        ptdt_pkg::OP_ADD: begin
                            if (free_found) begin
                                r_occ[free_idx] <= i_req.task_id != '0;
                                r_rdy[free_idx] <= 1'b0;
                            end
                        end
                        ptdt_pkg::OP_DEL: begin
                            if (32'(i_req.slot) < 32'(SLOTS)) begin
                                r_occ[i_req.slot[IW-1:0]] <= 1'b0;
                                r_rdy[i_req.slot[IW-1:0]] <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (walk_go) begin
                if (r_pv && r_occ[r_pidx]) begin
                    if (r_op == ptdt_pkg::OP_TICK) begin
                        r_rdy[r_pidx] <= proc_ent.pending != '0;
                    end else if (r_rdy[r_pidx]) begin
                        if (r_rdata.period == '0) begin
                            r_occ[r_pidx] <= 1'b0;
                            r_rdy[r_pidx] <= 1'b0;
                        end else begin
                            r_rdy[r_pidx] <= proc_ent.pending != '0;
                        end
                    end
                end
                r_pv <= !r_rdone;
                if (r_ridx == IW'(SLOTS - 1)) begin
                    r_rdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ptdt_pkg::ST_IDLE) begin
            if (accept) begin
                r_op <= i_req.op;
            end
            r_ridx <= '0;
        end else if (walk_go) begin
            r_pidx <= r_ridx;
            if (r_ridx != IW'(SLOTS - 1)) begin
                r_ridx <= r_ridx + IW'(1);
            end
        end
        if (res_load) begin
            if (r_state == ptdt_pkg::ST_IDLE) begin
                r_kind       <= ptdt_pkg::KIND_ADD;
                r_slot_index <= free_found ? ptdt_pkg::SlotW'(free_idx) : '0;
                r_full       <= !free_found;
                r_task_out   <= '0;
                r_last       <= 1'b1;
            end else begin
                r_kind       <= ptdt_pkg::KIND_DISPATCH;
                r_slot_index <= ptdt_pkg::SlotW'(r_pidx);
                r_full       <= 1'b0;
                r_task_out   <= r_rdata.task_id;
                r_last       <= !later_rdy;
            end
        end
    end

    assign i_req.ready       = req_ready;
    assign o_res.valid       = r_ov;
    assign o_res.kind        = r_kind;
    assign o_res.slot_index  = r_slot_index;
    assign o_res.full_res    = r_full;
    assign o_res.task_id_out = r_task_out;
    assign o_res.last        = r_last;

endmodule

// ===== rtl/ptdt_chk.sv =====
module ptdt_chk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  ptdt_pkg::t_op                i_req_op,
    input  logic                         i_res_valid,
    input  logic                         i_res_ready,
    input  ptdt_pkg::t_kind              i_res_kind,
    input  logic [ptdt_pkg::SlotW-1:0]   i_res_slot_index,
    input  logic                         i_res_full,
    input  logic [ptdt_pkg::IdW-1:0]     i_res_task_id_out,
    input  logic                         i_res_last
);

    // stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_slot_index)
            && $stable(i_res_task_id_out) && $stable(i_res_kind) && $stable(i_res_last))
        else $error("result changed while stalled");

    // add reply follows its request at once
    a_add_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_op == ptdt_pkg::OP_ADD
            |=> i_res_valid && i_res_kind == ptdt_pkg::KIND_ADD && i_res_last)
        else $error("add request gave no reply");

    a_full_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_full |-> i_res_kind == ptdt_pkg::KIND_ADD && i_res_slot_index == '0)
        else $error("bad full reply");

    // dispatch only from an occupied slot
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind == ptdt_pkg::KIND_DISPATCH |-> !i_res_full
            && i_res_task_id_out != '0)
        else $error("dispatch of an empty slot");

endmodule

bind periodic_task_dispatch_table_unit ptdt_chk u_ptdt_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_req_op          (i_req.op),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_kind        (o_res.kind),
    .i_res_slot_index  (o_res.slot_index),
    .i_res_full        (o_res.full_res),
    .i_res_task_id_out (o_res.task_id_out),
    .i_res_last        (o_res.last)
);

// ===== sim/tb_top.sv =====
module tb_top;

    localparam int SLOTS = 10;
    localparam int HalfPeriod = 5;
    localparam int ResetCycles = 12;
    localparam int ShownMismatches = 100;
    localparam int RandomRequests = 170;
    localparam int HoldCycles = 120;

    typedef struct {
        ptdt_pkg::t_kind            kind;
        logic [ptdt_pkg::SlotW-1:0] slot_index;
        logic                       full_res;
        logic [ptdt_pkg::IdW-1:0]   task_id;
        logic                       last;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ptdt_req_if req_if ();
    ptdt_res_if res_if ();

    periodic_task_dispatch_table_unit #(.SLOTS(SLOTS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always #HalfPeriod i_clk = ~i_clk;

    // shadow copy of the slot table
    logic [ptdt_pkg::IdW-1:0]   tbl_task   [SLOTS];
    logic [ptdt_pkg::TickW-1:0] tbl_delay  [SLOTS];
    logic [ptdt_pkg::TickW-1:0] tbl_period [SLOTS];
    logic [ptdt_pkg::PendW-1:0] tbl_pend   [SLOTS];

    t_reply replies_due [$];

    int  errors = 0;
    int  n_requests = 0;
    int  n_replies = 0;
    int  n_dispatch = 0;
    int  n_full = 0;
    bit  idle_on = 1'b1;
    int  rx_hold = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        if (errors < ShownMismatches) begin
            $display("mismatch at result %0d: %s got %0d want %0d", n_replies, what, got, want);
        end
        errors++;
    endtask

    function automatic void clear_entry(int s);
        tbl_task[s]   = '0;
        tbl_delay[s]  = '0;
        tbl_period[s] = '0;
        tbl_pend[s]   = '0;
    endfunction

    // advances the shadow table by one request and queues the replies it causes
    function automatic void schedule_request(ptdt_pkg::t_op op,
                                             logic [ptdt_pkg::IdW-1:0] id,
                                             logic [ptdt_pkg::TickW-1:0] dly,
                                             logic [ptdt_pkg::TickW-1:0] per,
                                             logic [ptdt_pkg::SlotW-1:0] sl);
        int     free_slot;
        int     last_ready;
        t_reply r;
        case (op)
            ptdt_pkg::OP_ADD: begin
                free_slot = -1;
                for (int s = SLOTS - 1; s >= 0; s--) begin
                    if (tbl_task[s] == '0) free_slot = s;
                end
                r.kind     = ptdt_pkg::KIND_ADD;
                r.task_id  = '0;
                r.last     = 1'b1;
                if (free_slot < 0) begin
                    r.slot_index = '0;
                    r.full_res   = 1'b1;
                end else begin
                    tbl_task[free_slot]   = id;
                    tbl_delay[free_slot]  = dly;
                    tbl_period[free_slot] = per;
                    tbl_pend[free_slot]   = '0;
                    r.slot_index = ptdt_pkg::SlotW'(free_slot);
                    r.full_res   = 1'b0;
                end
                replies_due.push_back(r);
            end
            ptdt_pkg::OP_DEL: begin
                if (int'(sl) < SLOTS) clear_entry(int'(sl));
            end
            ptdt_pkg::OP_TICK: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (tbl_task[s] != '0) begin
                        tbl_delay[s] = tbl_delay[s] - 1'b1;
                        if (tbl_delay[s] == '0) begin
                            if (tbl_pend[s] != ptdt_pkg::PendMax) begin
                                tbl_pend[s] = tbl_pend[s] + 1'b1;
                            end
                            if (tbl_period[s] != '0) tbl_delay[s] = tbl_period[s];
                        end
                    end
                end
            end
            default: begin
                last_ready = -1;
                for (int s = 0; s < SLOTS; s++) begin
                    if (tbl_task[s] != '0 && tbl_pend[s] != '0) last_ready = s;
                end
                for (int s = 0; s < SLOTS; s++) begin
                    if (tbl_task[s] != '0 && tbl_pend[s] != '0) begin
                        r.kind       = ptdt_pkg::KIND_DISPATCH;
                        r.slot_index = ptdt_pkg::SlotW'(s);
                        r.full_res   = 1'b0;
                        r.task_id    = tbl_task[s];
                        r.last       = (s == last_ready);
                        replies_due.push_back(r);
                        tbl_pend[s] = tbl_pend[s] - 1'b1;
                        if (tbl_period[s] == '0) clear_entry(s);
                    end
                end
            end
        endcase
    endfunction

    task automatic send_request(ptdt_pkg::t_op op, logic [ptdt_pkg::IdW-1:0] id,
                                logic [ptdt_pkg::TickW-1:0] dly,
                                logic [ptdt_pkg::TickW-1:0] per,
                                logic [ptdt_pkg::SlotW-1:0] sl);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.op          <= op;
        req_if.task_id     <= id;
        req_if.delay_load  <= dly;
        req_if.period_load <= per;
        req_if.slot        <= sl;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        schedule_request(op, id, dly, per, sl);
        n_requests++;
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        idle_on = 1'b1;
        send_request(ptdt_pkg::OP_ADD, 8'hFF, 32'd1, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_ADD, 8'h00, 32'd2, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_ADD, 8'h01, 32'd2, 32'd3, 4'd0);
        // zero delay wraps on the first tick
        send_request(ptdt_pkg::OP_ADD, 8'h80, 32'd0, 32'hFFFF_FFFF, 4'd0);
        send_request(ptdt_pkg::OP_ADD, 8'h55, 32'hFFFF_FFFF, 32'd1, 4'd0);
        send_request(ptdt_pkg::OP_RUN, 8'h00, 32'd0, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_RUN, 8'h00, 32'd0, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_DEL, 8'h00, 32'd0, 32'd0, 4'd15);
        send_request(ptdt_pkg::OP_DEL, 8'h00, 32'd0, 32'd0, 4'd10);
        send_request(ptdt_pkg::OP_DEL, 8'h00, 32'd0, 32'd0, 4'd2);
        // fill the table, the last add finds it full
        for (int k = 0; k < 9; k++) begin
            send_request(ptdt_pkg::OP_ADD, ptdt_pkg::IdW'(8'hA0 + k), 32'd1,
                         ptdt_pkg::TickW'(k % 2), 4'd0);
        end
        send_request(ptdt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_RUN, 8'h00, 32'd0, 32'd0, 4'd0);
        for (int s = 0; s < SLOTS; s++) begin
            send_request(ptdt_pkg::OP_DEL, 8'h00, 32'd0, 32'd0, ptdt_pkg::SlotW'(s));
        end
    endtask

    task automatic test_pressure();
        idle_on = 1'b1;
        rx_hold = HoldCycles;
        for (int k = 0; k < SLOTS; k++) begin
            send_request(ptdt_pkg::OP_ADD, ptdt_pkg::IdW'($urandom_range(1, 255)),
                         32'd1, 32'd2, 4'd0);
        end
        send_request(ptdt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_RUN, 8'h00, 32'd0, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_RUN, 8'h00, 32'd0, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 4'd0);
        send_request(ptdt_pkg::OP_RUN, 8'h00, 32'd0, 32'd0, 4'd0);
        pause_until_drained();
        for (int s = 0; s < SLOTS; s++) begin
            send_request(ptdt_pkg::OP_DEL, 8'h00, 32'd0, 32'd0, ptdt_pkg::SlotW'(s));
        end
    endtask

    task automatic test_random();
        int                         pick;
        ptdt_pkg::t_op              op;
        logic [ptdt_pkg::IdW-1:0]   id;
        logic [ptdt_pkg::TickW-1:0] dly;
        logic [ptdt_pkg::TickW-1:0] per;
        logic [ptdt_pkg::SlotW-1:0] sl;
        for (int i = 0; i < RandomRequests; i++) begin
            if (i % 40 == 0) idle_on = ((i / 40) % 2 == 0);
            pick = $urandom_range(0, 99);
            id   = ($urandom_range(0, 15) == 0) ? '0 : ptdt_pkg::IdW'($urandom_range(1, 255));
            if ($urandom_range(0, 5) == 0) begin
                dly = $urandom();
                per = $urandom();
            end else begin
                dly = ptdt_pkg::TickW'($urandom_range(1, 6));
                per = ptdt_pkg::TickW'($urandom_range(0, 4));
            end
            sl = ptdt_pkg::SlotW'($urandom_range(0, 15));
            if (pick < 25) op = ptdt_pkg::OP_ADD;
            else if (pick < 45) op = ptdt_pkg::OP_DEL;
            else if (pick < 75) op = ptdt_pkg::OP_TICK;
            else op = ptdt_pkg::OP_RUN;
            send_request(op, id, dly, per, sl);
            if ($urandom_range(0, 29) == 0) pause_until_drained();
        end
    endtask

    initial begin : result_sink
        int     w;
        t_reply want;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            w = idle_on ? $urandom_range(0, 3) : 0;
            if (rx_hold > 0) begin
                w = rx_hold;
                rx_hold = 0;
            end
            if (w > 0) begin
                @(negedge i_clk);
                res_if.ready <= 1'b0;
                repeat (w - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected result, slot", res_if.slot_index, 0);
            end else begin
                want = replies_due.pop_front();
                if (res_if.kind !== want.kind) report_mismatch("kind", res_if.kind, want.kind);
                if (res_if.slot_index !== want.slot_index) begin
                    report_mismatch("slot_index", res_if.slot_index, want.slot_index);
                end
                if (res_if.full_res !== want.full_res) begin
                    report_mismatch("full_res", res_if.full_res, want.full_res);
                end
                if (res_if.task_id_out !== want.task_id) begin
                    report_mismatch("task_id_out", res_if.task_id_out, want.task_id);
                end
                if (res_if.last !== want.last) report_mismatch("last", res_if.last, want.last);
            end
            n_replies++;
            if (res_if.kind === ptdt_pkg::KIND_DISPATCH) n_dispatch++;
            if (res_if.full_res === 1'b1) n_full++;
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        req_if.valid       = 1'b0;
        req_if.op          = ptdt_pkg::OP_ADD;
        req_if.task_id     = '0;
        req_if.delay_load  = '0;
        req_if.period_load = '0;
        req_if.slot        = '0;
        for (int s = 0; s < SLOTS; s++) clear_entry(s);
        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_pressure();
        test_random();

        pause_until_drained();
        repeat (4 * SLOTS) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            report_mismatch("results never delivered", replies_due.size(), 0);
        end
        $display("run: %0d requests, %0d results, %0d dispatches, %0d full-table replies",
                 n_requests, n_replies, n_dispatch, n_full);
        $display("run: add/delete/tick/run, full table, zero-delay wrap, output hold-off");
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ptdt_pkg.sv
rtl/ptdt_ifs.sv
rtl/periodic_task_dispatch_table_unit.sv
rtl/ptdt_chk.sv
sim/tb_top.sv
